// File: hw/rtl/sib_pkg.sv
// Shared types and codes for the snapshot interpolation buffer.
// No dependencies.
package sib_pkg;
	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_STALE    = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_HIT      = 3'd3;
	localparam logic [2:0] ST_NOBRACK  = 3'd4;
	localparam logic [2:0] ST_MISSING  = 3'd5;

	// Entity record as stored in the record memory
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] ang;
	} rec_t;
endpackage

// File: hw/rtl/snapshot_interpolation_buffer.sv
// Snapshot interpolation buffer: a dropped push goes from S_PUSH to the result, a stored
// one on through S_QWAIT and S_PWR; a query walks the slots serially, scans records twice
// over the one read port and runs the 49-step divider.
// One item at a time; the input stalls until the result beat is taken.
// Reset empties the ring; memories are not cleared (read only once written).
module snapshot_interpolation_buffer #(
	parameter int CAPACITY = 16,
	parameter int MAX_ENTITIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [31:0] tick,
	input  logic        first_of_snapshot,
	input  logic        entity_valid,
	input  logic [31:0] entity_id,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] angle,
	input  logic [47:0] render_tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_angle,
	output logic        in_range,
	output logic [31:0] newest_tick,
	output logic [31:0] oldest_tick
);
	import sib_pkg::*;

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
	localparam int NW = $clog2(MAX_ENTITIES + 1);
	localparam int AW = SW + EW;
	localparam int DEPTH = CAPACITY << EW;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_PUSH  = 14'b00000000000010,
		S_PWR   = 14'b00000000000100,
		S_QOLD  = 14'b00000000001000,
		S_QWALK = 14'b00000000010000,
		S_QWAIT = 14'b00000000100000,
		S_QPICK = 14'b00000001000000,
		S_SCAN  = 14'b00000010000000,
		S_SCHK  = 14'b00000100000000,
		S_DIV   = 14'b00001000000000,
		S_DWAIT = 14'b00010000000000,
		S_MUL   = 14'b00100000000000,
		S_BLEND = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// slot memories and record memory
	logic [31:0]   tick_mem [CAPACITY];
	logic [NW-1:0] cnt_mem  [CAPACITY];
	rec_t          rec_mem  [DEPTH];

	logic [SW-1:0] trd_addr;
	logic [31:0]   trd_q;
	logic [NW-1:0] crd_q;
	logic [AW-1:0] rrd_addr;
	rec_t          rrd_q;

	logic [SW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic          disc_q;
	logic          evict_q;
	logic [31:0]   newest_tick_q;
	logic [31:0]   oldest_tick_q;

	// captured beat
	logic        first_q, evalid_q;
	logic [31:0] tick_in_q, id_q;
	rec_t        rec_in_q;
	logic [47:0] rt_q;

	// query working registers
	logic [CW-1:0] pos_q;
	logic [31:0]   prev_tick_q;
	logic [31:0]   prev_tick0_q;
	logic          found_q;
	logic [SW-1:0] s0_q;
	logic [31:0]   t0_q, t1_q;
	logic          side_q;
	logic [NW-1:0] k_q;
	rec_t          ra_q, rb_q;
	logic [16:0]   alpha_q;
	logic [1:0]    lane_q;
	logic signed [49:0] prod_q;
	logic [31:0]   bx_q, by_q;

	logic          div_start, div_done;
	logic [48:0]   div_quo;

	logic          res_valid_q;
	logic [2:0]    res_status_q;
	logic [31:0]   res_x_q, res_y_q, res_a_q;
	logic          res_range_q;

	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
			input logic [CW-1:0] p);
		logic [CW:0] s;
		s = {{(CW+1-SW){1'b0}}, base} + {1'b0, p};
		if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
		return s[SW-1:0];
	endfunction

	logic [SW-1:0] newest_slot;
	assign newest_slot = slot_of(oldest_q, CW'(count_q - CW'(1)));

	assign in_stall = (state_q != S_IDLE) || (res_valid_q && out_stall);
	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// blend operand selection
	logic signed [32:0] diff;
	always_comb begin
		case (lane_q)
			2'd0: diff = 33'(signed'(rb_q.x)) - 33'(signed'(ra_q.x));
			2'd1: diff = 33'(signed'(rb_q.y)) - 33'(signed'(ra_q.y));
			default: diff = 33'(signed'(rb_q.ang)) - 33'(signed'(ra_q.ang));
		endcase
	end
	logic [31:0] base_a;
	always_comb begin
		case (lane_q)
			2'd0: base_a = ra_q.x;
			2'd1: base_a = ra_q.y;
			default: base_a = ra_q.ang;
		endcase
	end
	logic signed [49:0] rounded;
	logic [31:0]        blended;
	assign rounded = prod_q + 50'sd32768;
	assign blended = 32'(base_a + 32'(rounded >>> 16));

	sib_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, 48'(rt_q - {t0_q, 16'd0})}),
		.den({17'd0, t1_q - t0_q}),
		.done(div_done), .quo(div_quo)
	);

	// memory ports, synchronous reads
	logic          twe, cwe, rwe;
	logic [SW-1:0] twa, cwa;
	logic [NW-1:0] cwd;
	logic [AW-1:0] rwa;
	always_ff @(posedge clk) begin
		if (twe) tick_mem[twa] <= tick_in_q;
		if (cwe) cnt_mem[cwa] <= cwd;
		if (rwe) rec_mem[rwa] <= rec_in_q;
		trd_q <= tick_mem[trd_addr];
		crd_q <= cnt_mem[trd_addr];
		rrd_q <= rec_mem[rrd_addr];
	end

	logic          stale;
	assign stale = (count_q != '0) && (tick_in_q <= newest_tick_q);
	logic [SW-1:0] s1_slot;
	assign s1_slot = slot_of(s0_q, CW'(1));

	always_comb begin
		twe = 1'b0; cwe = 1'b0; rwe = 1'b0;
		twa = newest_slot; cwa = newest_slot; cwd = '0;
		rwa = {newest_slot, k_q[EW-1:0]};
		trd_addr = newest_slot;
		rrd_addr = {(side_q ? s1_slot : s0_q), k_q[EW-1:0]};
		div_start = 1'b0;
		case (state_q)
			S_PWR: begin
				rwe = evalid_q && (crd_q < NW'(MAX_ENTITIES));
				rwa = {newest_slot, crd_q[EW-1:0]};
				cwe = rwe;
				cwd = NW'(crd_q + NW'(1));
				// fetch the tick of the oldest slot for an eviction
				trd_addr = oldest_q;
			end
			S_QWALK: trd_addr = slot_of(oldest_q, pos_q);
			S_QWAIT: trd_addr = side_q ? newest_slot : slot_of(oldest_q, pos_q);
			S_QPICK: trd_addr = side_q ? s1_slot : s0_q;
			S_SCAN, S_SCHK: trd_addr = side_q ? s1_slot : s0_q;
			S_DIV: div_start = 1'b1;
			default: ;
		endcase
		if (state_q == S_PUSH && first_q && !stale) begin
			twe = 1'b1;
			cwe = 1'b1;
			cwd = '0;
			twa = (count_q == CW'(CAPACITY)) ? oldest_q : slot_of(oldest_q, count_q);
			cwa = twa;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			oldest_q <= '0;
			count_q <= '0;
			disc_q <= 1'b0;
			evict_q <= 1'b0;
			res_valid_q <= 1'b0;
			newest_tick_q <= '0;
			oldest_tick_q <= '0;
			res_status_q <= ST_STORED;
			res_x_q <= '0; res_y_q <= '0; res_a_q <= '0;
			res_range_q <= 1'b0;
			pos_q <= '0;
			prev_tick_q <= '0;
			found_q <= 1'b0;
			s0_q <= '0;
			t0_q <= '0; t1_q <= '0;
			side_q <= 1'b0;
			k_q <= '0;
			ra_q <= '0; rb_q <= '0;
			alpha_q <= '0;
			lane_q <= '0;
			prod_q <= '0;
			bx_q <= '0; by_q <= '0;
		end else begin
			if (res_valid_q && !out_stall) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_acc) state_q <= action ? S_QOLD : S_PUSH;
				S_PUSH: begin
					res_range_q <= 1'b0;
					res_x_q <= '0; res_y_q <= '0; res_a_q <= '0;
					if (first_q) begin
						if (stale) begin
							disc_q <= 1'b1;
							res_status_q <= ST_STALE;
							state_q <= S_DONE;
						end else begin
							disc_q <= 1'b0;
							newest_tick_q <= tick_in_q;
							if (count_q == CW'(CAPACITY)) begin
								oldest_q <= slot_of(oldest_q, CW'(1));
								evict_q <= 1'b1;
							end else begin
								count_q <= CW'(count_q + CW'(1));
								if (count_q == '0) oldest_tick_q <= tick_in_q;
							end
							state_q <= S_QWAIT;
							side_q <= 1'b1;
						end
					end else if (disc_q || count_q == '0) begin
						res_status_q <= ST_STALE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_QWAIT;
						side_q <= 1'b1;
					end
				end
				S_PWR: begin
					if (!evalid_q) res_status_q <= ST_STORED;
					else if (crd_q < NW'(MAX_ENTITIES)) res_status_q <= ST_STORED;
					else res_status_q <= ST_OVERFLOW;
					state_q <= S_DONE;
				end
				S_QOLD: begin
					res_x_q <= '0; res_y_q <= '0; res_a_q <= '0;
					res_range_q <= 1'b0;
					if (count_q < CW'(2)) begin
						res_status_q <= ST_NOBRACK;
						state_q <= S_DONE;
					end else begin
						res_range_q <= (rt_q >= {oldest_tick_q, 16'd0}) &&
							(rt_q <= {newest_tick_q, 16'd0});
						pos_q <= '0;
						found_q <= 1'b0;
						side_q <= 1'b0;
						state_q <= S_QWALK;
					end
				end
				S_QWALK: state_q <= S_QWAIT;
				S_QWAIT: begin
					if (!side_q && state_q == S_QWAIT) begin
						// trd_q holds tick at pos_q
						if (pos_q != '0 && !found_q && rt_q >= {prev_tick_q, 16'd0} &&
								rt_q < {trd_q, 16'd0}) begin
							found_q <= 1'b1;
							s0_q <= slot_of(oldest_q, CW'(pos_q - CW'(1)));
							t0_q <= prev_tick_q; t1_q <= trd_q;
						end
						prev_tick_q <= trd_q;
						if (pos_q == CW'(count_q - CW'(1))) begin
							state_q <= S_QPICK;
						end else begin
							pos_q <= CW'(pos_q + CW'(1));
							state_q <= S_QWALK;
						end
					end else begin
						// push: count read of newest slot done
						state_q <= S_PWR;
					end
				end
				S_QPICK: begin
					if (found_q) begin
						k_q <= '0; side_q <= 1'b0;
						state_q <= S_SCAN;
					end else if (rt_q == {newest_tick_q, 16'd0}) begin
						s0_q <= slot_of(oldest_q, CW'(count_q - CW'(2)));
						t0_q <= prev_tick0_q; t1_q <= newest_tick_q;
						found_q <= 1'b1;
						k_q <= '0; side_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						res_status_q <= ST_NOBRACK;
						state_q <= S_DONE;
					end
				end
				S_SCAN: state_q <= S_SCHK;
				S_SCHK: begin
					// crd_q is the count of the scanned slot, rrd_q record k
					if (k_q < crd_q && k_q < NW'(MAX_ENTITIES) && rrd_q.id == id_q) begin
						if (side_q) begin
							rb_q <= rrd_q;
							state_q <= S_DIV;
						end else begin
							ra_q <= rrd_q;
							side_q <= 1'b1;
							k_q <= '0;
							state_q <= S_SCAN;
						end
					end else if (k_q + NW'(1) >= crd_q || k_q + NW'(1) >= NW'(MAX_ENTITIES)) begin
						res_status_q <= ST_MISSING;
						state_q <= S_DONE;
					end else begin
						k_q <= NW'(k_q + NW'(1));
						state_q <= S_SCAN;
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: if (div_done) begin
					alpha_q <= (div_quo > 49'd65536) ? 17'd65536 : div_quo[16:0];
					lane_q <= 2'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= diff * signed'({33'd0, alpha_q});
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					case (lane_q)
						2'd0: bx_q <= blended;
						2'd1: by_q <= blended;
						default: begin
							res_x_q <= bx_q; res_y_q <= by_q; res_a_q <= blended;
							res_status_q <= ST_HIT;
						end
					endcase
					if (lane_q == 2'd2) state_q <= S_DONE;
					else begin
						lane_q <= 2'(lane_q + 2'd1);
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					// take the new oldest tick after an eviction, read during S_PWR
					if (evict_q) begin
						oldest_tick_q <= trd_q;
						evict_q <= 1'b0;
					end
					if (!res_valid_q || !out_stall) begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tick of the slot before the newest, kept from the walk
	always_ff @(posedge clk) begin
		if (state_q == S_QWAIT && !side_q && pos_q == CW'(count_q - CW'(2)))
			prev_tick0_q <= trd_q;
	end

	// capture the beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			first_q <= first_of_snapshot;
			evalid_q <= entity_valid;
			tick_in_q <= tick;
			id_q <= entity_id;
			rec_in_q <= '{id: entity_id, x: pos_x, y: pos_y, ang: angle};
			rt_q <= render_tick;
		end
	end

	assign out_valid   = res_valid_q;
	assign status      = res_status_q;
	assign out_x       = res_x_q;
	assign out_y       = res_y_q;
	assign out_angle   = res_a_q;
	assign in_range    = res_range_q;
	assign newest_tick = (count_q == '0) ? 32'd0 : newest_tick_q;
	assign oldest_tick = (count_q == '0) ? 32'd0 : oldest_tick_q;
endmodule

// File: hw/rtl/sib_div.sv
// Restoring divider, one quotient bit per cycle, for the blend factor.
// Depends on nothing.
module sib_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] num,
	input  logic [48:0] den,
	output logic        done,
	output logic [48:0] quo
);
	logic [48:0] rem_q;
	logic [48:0] nq_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [49:0] trial;

	assign trial = {rem_q, nq_q[48]};
	assign quo = nq_q;

	// shift in one numerator bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd49;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q <= num;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= 49'(trial - {1'b0, den});
				nq_q <= {nq_q[47:0], 1'b1};
			end else begin
				rem_q <= trial[48:0];
				nq_q <= {nq_q[47:0], 1'b0};
			end
		end
	end
endmodule

// File: bench/snapshot_interpolation_buffer_test.sv
// Self-checking bench for the snapshot interpolation buffer: pushes snapshots, queries
// positions and compares every result beat against an in-bench ring model.
// Depends on sib_pkg and snapshot_interpolation_buffer.
`timescale 1ns / 100ps

module snapshot_interpolation_buffer_test;
	import sib_pkg::*;

	localparam int CAP = 16;
	localparam int MAXE = 64;

	typedef struct {
		bit        action;
		bit [31:0] tick;
		bit        opens;
		bit        ev;
		bit [31:0] id;
		bit [31:0] x;
		bit [31:0] y;
		bit [31:0] ang;
		bit [47:0] rt;
	} beat_t;

	typedef struct {
		bit [2:0]  status;
		bit [31:0] x;
		bit [31:0] y;
		bit [31:0] ang;
		bit        in_range;
		bit [31:0] newest;
		bit [31:0] oldest;
	} answer_t;

	// Ring model plus the queue of answers still owed by the block
	class ring_scoreboard;
		bit [31:0] ticks [CAP];
		int        counts [CAP];
		bit [31:0] ids [CAP*MAXE];
		bit [31:0] xs [CAP*MAXE];
		bit [31:0] ys [CAP*MAXE];
		bit [31:0] angs [CAP*MAXE];
		int        oldest_slot;
		int        count;
		bit        discarding;
		answer_t   owed [$];
		int        errors;
		int        seen [8];

		function int slot(int p);
			return (oldest_slot + p) % CAP;
		endfunction

		function bit [31:0] newest_tick();
			return count > 0 ? ticks[slot(count - 1)] : 32'd0;
		endfunction

		function bit [31:0] oldest_tick();
			return count > 0 ? ticks[slot(0)] : 32'd0;
		endfunction

		function int find(int s, bit [31:0] id);
			for (int k = 0; k < counts[s]; k++)
				if (ids[s*MAXE + k] == id) return s*MAXE + k;
			return -1;
		endfunction

		// a + round((b - a) * alpha / 2^16), ties toward +inf
		function bit [31:0] mix(bit [31:0] a, bit [31:0] b, longint alpha);
			longint sa, p;
			sa = longint'(int'(a));
			p = (longint'(int'(b)) - sa) * alpha + 32768;
			return 32'(sa + (p >>> 16));
		endfunction

		function void push(beat_t b, ref answer_t r);
			int  s, idx;
			bit  go;
			go = 1;
			if (b.opens) begin
				if (count > 0 && b.tick <= newest_tick()) begin
					discarding = 1;
					r.status = ST_STALE;
					go = 0;
				end else begin
					discarding = 0;
					if (count >= CAP) begin
						oldest_slot = (oldest_slot + 1) % CAP;
						count--;
					end
					s = slot(count);
					ticks[s] = b.tick;
					counts[s] = 0;
					count++;
				end
			end else if (discarding || count == 0) begin
				r.status = ST_STALE;
				go = 0;
			end
			if (go) begin
				r.status = ST_STORED;
				if (b.ev) begin
					s = slot(count - 1);
					if (counts[s] >= MAXE) begin
						r.status = ST_OVERFLOW;
					end else begin
						idx = s*MAXE + counts[s];
						ids[idx] = b.id;
						xs[idx] = b.x;
						ys[idx] = b.y;
						angs[idx] = b.ang;
						counts[s]++;
					end
				end
			end
		endfunction

		function void query(beat_t b, ref answer_t r);
			longint unsigned t0, t1, told, tnew, rt, alpha;
			int  s0, s1, a, c;
			bit  found;
			found = 0;
			rt = b.rt;
			r.status = ST_NOBRACK;
			if (count < 2) return;
			told = longint'(oldest_tick()) << 16;
			tnew = longint'(newest_tick()) << 16;
			r.in_range = rt >= told && rt <= tnew;
			for (int i = 0; i + 1 < count && !found; i++) begin
				t0 = longint'(ticks[slot(i)]) << 16;
				t1 = longint'(ticks[slot(i + 1)]) << 16;
				if (rt >= t0 && rt < t1) begin
					s0 = slot(i);
					s1 = slot(i + 1);
					found = 1;
				end
			end
			// exact newest tick uses the last pair
			if (!found && rt == tnew) begin
				s0 = slot(count - 2);
				s1 = slot(count - 1);
				found = 1;
			end
			if (!found) return;
			a = find(s0, b.id);
			c = find(s1, b.id);
			if (a < 0 || c < 0) begin
				r.status = ST_MISSING;
				return;
			end
			t0 = longint'(ticks[s0]) << 16;
			t1 = longint'(ticks[s1]) << 16;
			alpha = ((rt - t0) << 16) / (t1 - t0);
			if (alpha > 65536) alpha = 65536;
			r.status = ST_HIT;
			r.x = mix(xs[a], xs[c], alpha);
			r.y = mix(ys[a], ys[c], alpha);
			r.ang = mix(angs[a], angs[c], alpha);
		endfunction

		function void note_beat(beat_t b);
			answer_t r;
			r = '{default: 0};
			if (b.action) query(b, r);
			else push(b, r);
			r.newest = newest_tick();
			r.oldest = oldest_tick();
			owed.insert(owed.size(), r);
		endfunction

		function void field(string name, bit [31:0] e, bit [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
			end
		endfunction

		function void check_answer(answer_t a);
			answer_t e;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, status %0d", $time, a.status);
				return;
			end
			e = owed[0];
			owed.delete(0);
			seen[e.status]++;
			field("status", e.status, a.status);
			field("out_x", e.x, a.x);
			field("out_y", e.y, a.y);
			field("out_angle", e.ang, a.ang);
			field("in_range", e.in_range, a.in_range);
			field("newest_tick", e.newest, a.newest);
			field("oldest_tick", e.oldest, a.oldest);
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        action = 0;
	logic [31:0] tick = 0;
	logic        first_of_snapshot = 0;
	logic        entity_valid = 0;
	logic [31:0] entity_id = 0;
	logic signed [31:0] pos_x = 0;
	logic signed [31:0] pos_y = 0;
	logic signed [31:0] angle = 0;
	logic [47:0] render_tick = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_angle;
	logic        in_range;
	logic [31:0] newest_tick;
	logic [31:0] oldest_tick;

	ring_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	int hold_cycles = 0;
	int sent = 0;
	bit [31:0] tick_floor = 0;

	snapshot_interpolation_buffer dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Check each result beat, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_answer('{status, out_x, out_y, out_angle, in_range,
				newest_tick, oldest_tick});
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= $urandom_range(99) < recv_stall;
		end
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	// Offer one beat and hold it until taken, then maybe idle
	task automatic send(beat_t b);
		action <= b.action;
		tick <= b.tick;
		first_of_snapshot <= b.opens;
		entity_valid <= b.ev;
		entity_id <= b.id;
		pos_x <= b.x;
		pos_y <= b.y;
		angle <= b.ang;
		render_tick <= b.rt;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_beat(b);
		sent++;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
	endtask

	task automatic rec(bit opens, bit [31:0] t, bit ev, bit [31:0] id,
		bit [31:0] x, bit [31:0] y, bit [31:0] a);
		send('{0, t, opens, ev, id, x, y, a, 48'($urandom)});
	endtask

	task automatic ask(bit [31:0] id, bit [47:0] rt);
		send('{1, $urandom, $urandom_range(1), $urandom_range(1), id,
			$urandom, $urandom, $urandom, rt});
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic drain();
		in_valid <= 0;
		while (sb.owed.size() > 0) @(posedge clk);
	endtask

	function automatic bit [31:0] pick_id();
		return $urandom_range(99) < 90 ? $urandom_range(9) : $urandom;
	endfunction

	// One snapshot: a fresh or stale opening record, then its followers
	task automatic random_snapshot();
		bit [32:0] t;
		int n, roll;
		roll = $urandom_range(99);
		if (sb.count > 0 && roll < 8) begin
			t = $urandom_range(sb.newest_tick(), 0);
		end else begin
			t = sb.newest_tick() + (roll < 12 ? $urandom_range(1 << 24, 1)
				: $urandom_range(300, 1));
			if (t < tick_floor) t = tick_floor;
			if (t > 33'hFFFF_FFFF) t = 33'hFFFF_FFFF;
		end
		roll = $urandom_range(99);
		n = roll < 3 ? $urandom_range(70, 65) : $urandom_range(6, 1);
		rec(1, t[31:0], $urandom_range(9) != 0, pick_id(), $urandom, $urandom, $urandom);
		for (int k = 1; k < n; k++)
			rec(0, $urandom, $urandom_range(19) != 0, pick_id(),
				$urandom, $urandom, $urandom);
	endtask

	task automatic random_query();
		longint unsigned told, tnew, rt;
		int roll;
		told = longint'(sb.oldest_tick()) << 16;
		tnew = longint'(sb.newest_tick()) << 16;
		roll = $urandom_range(99);
		if (roll < 10) rt = tnew;
		else if (roll < 18) rt = {$urandom, $urandom};
		else if (roll < 23) rt = told - $urandom_range(70000, 1);
		else if (roll < 28) rt = tnew + $urandom_range(70000, 1);
		else rt = told + ({$urandom, $urandom} % (tnew - told + 1));
		ask(pick_id(), rt[47:0]);
	endtask

	task automatic random_phase(int items, int idle, int stall, bit [31:0] floor_tick);
		int goal;
		send_idle = idle;
		recv_stall = stall;
		tick_floor = floor_tick;
		goal = sent + items;
		while (sent < goal) begin
			random_snapshot();
			repeat ($urandom_range(3)) random_query();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty ring, extremes, duplicates, empty records, stale snapshots
		rec(0, 32'd5, 1, 32'd1, 32'd1, 32'd1, 32'd1);
		ask(32'd0, 48'd0);
		rec(1, 32'd0, 1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		rec(0, 32'd0, 0, 32'd0, 32'd0, 32'd0, 32'd0);
		rec(0, 32'd0, 1, 32'hFFFF_FFFF, 32'd100, 32'hFFFF_FF00, 32'h0001_0000);
		rec(0, 32'd0, 1, 32'd0, 32'd9, 32'd9, 32'd9);
		ask(32'd0, 48'd0);
		rec(1, 32'd10, 1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
		rec(0, 32'd10, 1, 32'hFFFF_FFFF, 32'd200, 32'd0, 32'h8000_0000);
		ask(32'd0, 48'd10 << 16);
		ask(32'd0, 48'd5 << 16);
		ask(32'hFFFF_FFFF, (48'd3 << 16) + 48'h7FFF);
		ask(32'd7, 48'd4 << 16);
		ask(32'd0, 48'hFFFF_FFFF_FFFF);
		ask(32'd0, (48'd10 << 16) + 1);
		rec(1, 32'd10, 1, 32'd3, 32'd1, 32'd1, 32'd1);
		rec(0, 32'd10, 1, 32'd3, 32'd1, 32'd1, 32'd1);
		rec(1, 32'd11, 0, 32'd0, 32'd0, 32'd0, 32'd0);
		ask(32'd0, 48'd11 << 16);
		ask(32'd0, 48'd0);
		drain();

		random_phase(350, 0, 0, 32'd0);
		random_phase(350, 84, 0, 32'h3000_0000);

		// Hold results off long enough for the input to back up, then pause
		hold_cycles = 800;
		send_idle = 0;
		repeat (12) random_query();
		drain();

		random_phase(350, 0, 84, 32'h9000_0000);
		random_phase(350, 11, 11, 32'hFFFF_0000);
		rec(1, 32'hFFFF_FFFF, 1, 32'd2, $urandom, $urandom, $urandom);
		ask(32'd2, 48'hFFFF_FFFF_0000);
		drain();
		repeat (300) @(posedge clk);

		$display("Sent %0d beats: stored %0d, stale %0d, overflow %0d, hits %0d,",
			sent, sb.seen[ST_STORED], sb.seen[ST_STALE], sb.seen[ST_OVERFLOW],
			sb.seen[ST_HIT]);
		$display("no bracket %0d, missing %0d, errors %0d",
			sb.seen[ST_NOBRACK], sb.seen[ST_MISSING], sb.errors);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
